[src/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CBB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");

`define CBB_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");

`endif

[src/cbb_pkg.sv]
package cbb_pkg;

  localparam int COL_BITS  = 8;
  localparam int ROW_BITS  = 8;
  localparam int ADDR_BITS = COL_BITS + ROW_BITS;
  localparam logic [8:0] MAX_WIDTH  = 9'd256;
  localparam logic [8:0] MAX_HEIGHT = 9'd256;

  typedef enum logic [1:0] {
    ACT_HEADER = 2'd0,
    ACT_PIXEL  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OUTSIDE  = 2'd1,
    ST_READ_OUT = 2'd2,
    ST_NO_HDR   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_CANVAS_W = 3'd2,
    REG_CANVAS_H = 3'd3,
    REG_OUT_FMT  = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    FMT_BIT  = 2'd0,
    FMT_BYTE = 2'd1,
    FMT_HALF = 2'd2,
    FMT_WORD = 2'd3
  } fmt_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        rect_w;
    logic [15:0]        rect_h;
    logic [31:0]        pixel_value;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [8:0]  box_left;
    logic [8:0]  box_top;
    logic [8:0]  box_width;
    logic [8:0]  box_height;
    logic        has_data;
  } out_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] waddr;
    logic [31:0]          wdata;
    logic                 re;
    logic [ADDR_BITS-1:0] raddr;
  } ram_req_t;

endpackage

[src/cbb_canvas_ram.sv]
module cbb_canvas_ram
  import cbb_pkg::*;
(
  input  logic        clk,
  input  ram_req_t    req,
  output logic [31:0] rd_data
);

  logic [31:0] mem [0:(1 << ADDR_BITS) - 1];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

[src/cbb_ctrl.sv]
module cbb_ctrl
  import cbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output ram_req_t    ram_req,
  input  logic [31:0] ram_rd_data
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_RUN   = 3'b010,
    S_READ  = 3'b100
  } state_t;

  state_t state, state_next;

  logic signed [15:0] origin_x, origin_y;
  logic [8:0] canvas_width, canvas_height;
  logic [1:0] out_format;

  logic [8:0] box_l, box_t, box_r, box_b;
  logic [8:0] box_l_next, box_t_next, box_r_next, box_b_next;
  logic placed, placed_next;
  logic [15:0] src_col, src_row, src_col_next, src_row_next;
  logic signed [16:0] rx, ry;
  logic [15:0] rw, rh;
  logic ract, ract_next;
  logic [8:0] cx0, cx1, cy0, cy1;
  logic [ADDR_BITS-1:0] clr_addr;

  logic accept, take;
  logic [8:0] cw, ch;
  logic signed [17:0] hx, hy, hx0, hy0, hx1, hy1;
  logic hempty;
  logic signed [17:0] pcol, prow;
  logic pin;
  logic [8:0] bw, bh;
  logic rd_ok;
  logic [1:0] res_status, res_status_next;
  out_t out_next;
  logic [31:0] conv;

  assign cfg_ready = 1'b1;
  assign take      = out_valid && !out_stall;
  assign in_stall  = !(state == S_RUN && (!out_valid || !out_stall));
  assign accept    = in_valid && !in_stall;

  assign cw = (canvas_width == 9'd0) ? 9'd1 : (canvas_width > MAX_WIDTH ? MAX_WIDTH : canvas_width);
  assign ch = (canvas_height == 9'd0) ? 9'd1 :
              (canvas_height > MAX_HEIGHT ? MAX_HEIGHT : canvas_height);

  always_comb begin
    hx  = 18'(in_data.pos_x) - 18'(origin_x);
    hy  = 18'(in_data.pos_y) - 18'(origin_y);
    hx0 = (hx < 0) ? 18'sd0 : hx;
    hy0 = (hy < 0) ? 18'sd0 : hy;
    hx1 = hx + $signed({2'b00, in_data.rect_w});
    hy1 = hy + $signed({2'b00, in_data.rect_h});
    if (hx1 > $signed({9'd0, cw})) hx1 = $signed({9'd0, cw});
    if (hy1 > $signed({9'd0, ch})) hy1 = $signed({9'd0, ch});
    hempty = (hx1 <= hx0) || (hy1 <= hy0);
  end

  assign pcol = 18'(rx) + $signed({2'b00, src_col});
  assign prow = 18'(ry) + $signed({2'b00, src_row});
  assign pin  = pcol >= $signed({9'd0, cx0}) && pcol < $signed({9'd0, cx1}) &&
                prow >= $signed({9'd0, cy0}) && prow < $signed({9'd0, cy1});

  assign bw = box_r - box_l;
  assign bh = box_b - box_t;
  assign rd_ok = placed && ({1'b0, in_data.read_col} < bw) && ({1'b0, in_data.read_row} < bh);

  always_comb begin
    case (fmt_t'(out_format))
      FMT_BIT:  conv = {31'd0, ram_rd_data != 32'd0};
      FMT_BYTE: conv = {24'd0, ram_rd_data[7:0]};
      FMT_HALF: conv = {16'd0, ram_rd_data[15:0]};
      default:  conv = ram_rd_data;
    endcase
  end

  always_comb begin
    state_next      = state;
    box_l_next      = box_l;
    box_t_next      = box_t;
    box_r_next      = box_r;
    box_b_next      = box_b;
    placed_next     = placed;
    src_col_next    = src_col;
    src_row_next    = src_row;
    ract_next       = ract;
    res_status_next = ST_OK;
    ram_req         = '0;
    ram_req.raddr   = {in_data.read_row + box_t[7:0], in_data.read_col + box_l[7:0]};
    ram_req.waddr   = {prow[7:0], pcol[7:0]};
    ram_req.wdata   = in_data.pixel_value;
    if (state == S_CLEAR) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = clr_addr;
      ram_req.wdata = '0;
      if (&clr_addr) begin
        state_next = S_RUN;
      end
    end else if (state == S_READ) begin
      state_next = S_RUN;
    end else if (accept) begin
      case (action_t'(in_data.action))
        ACT_HEADER: begin
          src_col_next = '0;
          src_row_next = '0;
          ract_next    = (in_data.rect_w != 16'd0) && (in_data.rect_h != 16'd0);
          if (hempty) begin
            res_status_next = ST_OUTSIDE;
          end else if (!placed) begin
            box_l_next  = hx0[8:0];
            box_t_next  = hy0[8:0];
            box_r_next  = hx1[8:0];
            box_b_next  = hy1[8:0];
            placed_next = 1'b1;
          end else begin
            if (hx0[8:0] < box_l) box_l_next = hx0[8:0];
            if (hy0[8:0] < box_t) box_t_next = hy0[8:0];
            if (hx1[8:0] > box_r) box_r_next = hx1[8:0];
            if (hy1[8:0] > box_b) box_b_next = hy1[8:0];
          end
        end
        ACT_PIXEL: begin
          if (!ract) begin
            res_status_next = ST_NO_HDR;
          end else begin
            ram_req.we = pin;
            if ({1'b0, src_col} + 17'd1 >= {1'b0, rw}) begin
              src_col_next = '0;
              if ({1'b0, src_row} + 17'd1 >= {1'b0, rh}) begin
                src_row_next = '0;
                ract_next    = 1'b0;
              end else begin
                src_row_next = src_row + 16'd1;
              end
            end else begin
              src_col_next = src_col + 16'd1;
            end
          end
        end
        ACT_READ: begin
          if (rd_ok) begin
            ram_req.re = 1'b1;
            state_next = S_READ;
          end else begin
            res_status_next = ST_READ_OUT;
          end
        end
        default: begin
          box_l_next   = '0;
          box_t_next   = '0;
          box_r_next   = '0;
          box_b_next   = '0;
          placed_next  = 1'b0;
          ract_next    = 1'b0;
          src_col_next = '0;
          src_row_next = '0;
          state_next   = S_CLEAR;
        end
      endcase
    end
  end

  always_comb begin
    out_next.status     = res_status_next;
    out_next.read_value = '0;
    out_next.box_left   = box_l_next;
    out_next.box_top    = box_t_next;
    out_next.box_width  = box_r_next - box_l_next;
    out_next.box_height = box_b_next - box_t_next;
    out_next.has_data   = placed_next;
    if (state == S_READ) begin
      out_next.status     = ST_OK;
      out_next.read_value = conv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      origin_x      <= '0;
      origin_y      <= '0;
      canvas_width  <= MAX_WIDTH;
      canvas_height <= MAX_HEIGHT;
      out_format    <= '0;
      box_l         <= '0;
      box_t         <= '0;
      box_r         <= '0;
      box_b         <= '0;
      placed        <= 1'b0;
      src_col       <= '0;
      src_row       <= '0;
      ract          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state   <= state_next;
      box_l   <= box_l_next;
      box_t   <= box_t_next;
      box_r   <= box_r_next;
      box_b   <= box_b_next;
      placed  <= placed_next;
      src_col <= src_col_next;
      src_row <= src_row_next;
      ract    <= ract_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end else begin
        clr_addr <= '0;
      end
      if ((accept && state_next != S_READ) || state == S_READ) begin
        out_valid <= 1'b1;
      end else if (take) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_ORIGIN_X: origin_x      <= cfg_data;
          REG_ORIGIN_Y: origin_y      <= cfg_data;
          REG_CANVAS_W: canvas_width  <= cfg_data[8:0];
          REG_CANVAS_H: canvas_height <= cfg_data[8:0];
          REG_OUT_FMT:  out_format    <= cfg_data[1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((accept && state_next != S_READ) || state == S_READ) begin
      out_data <= out_next;
    end
    if (accept && in_data.action == ACT_HEADER) begin
      rx  <= hx[16:0];
      ry  <= hy[16:0];
      rw  <= in_data.rect_w;
      rh  <= in_data.rect_h;
      cx0 <= hempty ? 9'd0 : hx0[8:0];
      cx1 <= hempty ? 9'd0 : hx1[8:0];
      cy0 <= hempty ? 9'd0 : hy0[8:0];
      cy1 <= hempty ? 9'd0 : hy1[8:0];
    end
  end

endmodule

[src/clipped_blit_with_bounding_box.sv]
// Clipped rectangle blit into a 256x256 canvas of 32-bit mask pixels, with a
// bounding box of all placements. Header, pixel and clear transactions give
// their result the cycle after acceptance; a read inside the box reads the
// synchronous canvas memory and registers its result in the S_READ state,
// which stalls input. A new transaction is taken only in the run state when
// no result waits or the waiting result leaves in the same cycle, so one
// item per cycle is sustained for headers and pixels while the output is
// not stalled. After reset and each clear the canvas memory is zeroed one
// entry per cycle, input stalled; configuration writes are always taken.
`include "assert_macros.svh"
module clipped_blit_with_bounding_box
  import cbb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ram_req_t    ram_req;
  logic [31:0] ram_rd_data;
  logic        read_out;
  logic        box_empty;

  cbb_canvas_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  cbb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .ram_req     (ram_req),
    .ram_rd_data (ram_rd_data)
  );

  assign read_out  = out_valid && out_data.status == ST_READ_OUT;
  assign box_empty = out_data.box_width == 9'd0 && out_data.box_height == 9'd0;

  `CBB_ASSERT_NR(a_clear_after_reset, clk, rst |=> in_stall)
  `CBB_ASSERT(a_bad_read_zero, clk, rst, read_out |-> out_data.read_value == 32'd0)
  `CBB_ASSERT(a_empty_box, clk, rst, out_valid && !out_data.has_data |-> box_empty)

endmodule
